/* design/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define LBMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while rst is high
`define LBMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/lbmc_pkg.sv */
// package with mode codes, divider constants and shared types
package lbmc_pkg;

   localparam int unsigned LED_COUNT = 3;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned MODE_WIDTH = 3;

   // divider tops, each wraps to zero past its top
   localparam logic       DIV_TWO_TOP  = 1'd1;
   localparam logic [2:0] DIV_FIVE_TOP = 3'd4;
   localparam logic [3:0] DIV_TEN_TOP  = 4'd9;

   // register indexes of the csr channel
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE_LED0 = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE_LED1 = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE_LED2 = 2'd2;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_OFF       = 3'd0,
      MODE_EVERY1    = 3'd1,
      MODE_EVERY2    = 3'd2,
      MODE_EVERY5    = 3'd3,
      MODE_EVERY10   = 3'd4,
      MODE_FORCE_OFF = 3'd5,
      MODE_FORCE_ON  = 3'd6,
      MODE_FADE      = 3'd7
   } mode_type;

   // per-tick control from the shared dividers to each led
   typedef struct packed {
      logic fire;
      logic wrap_two;
      logic wrap_five;
      logic wrap_ten;
   } tick_type;

endpackage

/* design/lbmc_led_cell.sv */
// per-led mode tracking, save/restore and toggle logic
module lbmc_led_cell (
   input  logic               clock,
   input  logic               reset,
   input  lbmc_pkg::tick_type tick,
   input  lbmc_pkg::mode_type mode,
   output logic               level_next
);

   lbmc_pkg::mode_type last_mode_ff, last_mode_in;
   logic saved_ff, saved_in;
   logic level_ff, level_in;
   logic level_mid;
   logic flip;

   always_comb begin
      last_mode_in = last_mode_ff;
      saved_in     = saved_ff;
      level_mid    = level_ff;
      flip         = 1'b0;
      if (mode != last_mode_ff) begin
         last_mode_in = mode;
         if (mode != lbmc_pkg::MODE_OFF) begin
            saved_in = level_ff;
         end else begin
            level_mid = saved_ff;
         end
      end
      level_in = level_mid;
      unique case (mode)
         lbmc_pkg::MODE_EVERY1:    flip = 1'b1;
         lbmc_pkg::MODE_EVERY2:    flip = tick.wrap_two;
         lbmc_pkg::MODE_EVERY5:    flip = tick.wrap_five;
         lbmc_pkg::MODE_EVERY10:   flip = tick.wrap_ten;
         lbmc_pkg::MODE_FORCE_OFF: level_in = 1'b0;
         lbmc_pkg::MODE_FORCE_ON:  level_in = 1'b1;
         lbmc_pkg::MODE_OFF,
         lbmc_pkg::MODE_FADE:      flip = 1'b0;
         default:                  flip = 1'b0;
      endcase
      if (flip) begin
         level_in = ~level_mid;
      end
   end

   assign level_next = tick.fire ? level_in : level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_mode_ff <= lbmc_pkg::MODE_OFF;
         saved_ff     <= 1'b0;
         level_ff     <= 1'b0;
      end else if (tick.fire) begin
         last_mode_ff <= last_mode_in;
         saved_ff     <= saved_in;
         level_ff     <= level_in;
      end
   end

endmodule

/* design/led_blink_mode_controller_core.sv */
// top level of the three-led blink mode controller
//
// req channel: one beat per service tick, req_advance high advances the
// shared dividers (mod 2, 5, 10) and applies each led's mode; low holds
// all state and just reports the current levels.
// rsp channel: exactly one beat per req beat, in order, carrying the led
// levels after that tick.
// csr channel: writes mode_led0..2 at index 0..2, index 3 is ignored;
// csr_ready is always high. write only while the block is idle.
// path: an accepted req beat lands in the input register and moves into the
// output register once that register is free or draining, which raises
// rsp_valid. throughput: one beat per cycle while rsp_ready stays high, set
// by the single pass from input register to output register.
// stall: while rsp_ready is low the output register holds; the input
// register still takes one more beat, then req_ready drops.
// reset: synchronous, clears dividers, modes, saved and current levels,
// and empties both registers.
module led_blink_mode_controller_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_advance,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_led0_on,
   output logic                                 rsp_led1_on,
   output logic                                 rsp_led2_on,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lbmc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lbmc_pkg::MODE_WIDTH-1:0]      csr_data
);

   // mode registers
   lbmc_pkg::mode_type mode_ff [lbmc_pkg::LED_COUNT];

   // input register
   logic in_valid_ff;
   logic in_advance_ff;

   // output register
   logic rsp_valid_ff;
   logic [lbmc_pkg::LED_COUNT-1:0] rsp_level_ff;

   // shared dividers
   logic       div_two_ff, div_two_in;
   logic [2:0] div_five_ff, div_five_in;
   logic [3:0] div_ten_ff, div_ten_in;

   logic move;
   lbmc_pkg::tick_type tick;
   logic [lbmc_pkg::LED_COUNT-1:0] level_next;

   // the input beat moves on when the output register is free or draining
   assign move      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || move;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_advance_ff <= req_advance;
      end
   end

   // csr writes, out of range index falls through
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < lbmc_pkg::LED_COUNT; k++) begin
            mode_ff[k] <= lbmc_pkg::MODE_OFF;
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            lbmc_pkg::CSR_MODE_LED0: mode_ff[0] <= lbmc_pkg::mode_type'(csr_data);
            lbmc_pkg::CSR_MODE_LED1: mode_ff[1] <= lbmc_pkg::mode_type'(csr_data);
            lbmc_pkg::CSR_MODE_LED2: mode_ff[2] <= lbmc_pkg::mode_type'(csr_data);
            default: ;
         endcase
      end
   end

   // divider increment with wrap past the top
   always_comb begin
      div_two_in  = (div_two_ff == lbmc_pkg::DIV_TWO_TOP) ? 1'b0 : div_two_ff + 1'b1;
      div_five_in = (div_five_ff == lbmc_pkg::DIV_FIVE_TOP) ? 3'd0 : div_five_ff + 3'd1;
      div_ten_in  = (div_ten_ff == lbmc_pkg::DIV_TEN_TOP) ? 4'd0 : div_ten_ff + 4'd1;
   end

   always_comb begin
      tick.fire      = move && in_advance_ff;
      tick.wrap_two  = (div_two_in == 1'b0);
      tick.wrap_five = (div_five_in == 3'd0);
      tick.wrap_ten  = (div_ten_in == 4'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_two_ff  <= 1'b0;
         div_five_ff <= 3'd0;
         div_ten_ff  <= 4'd0;
      end else if (tick.fire) begin
         div_two_ff  <= div_two_in;
         div_five_ff <= div_five_in;
         div_ten_ff  <= div_ten_in;
      end
   end

   // one cell per led, each keeps its own last mode and levels
   for (genvar g = 0; g < lbmc_pkg::LED_COUNT; g++) begin : g_led
      lbmc_led_cell u_led (
         .clock      (clock),
         .reset      (reset),
         .tick       (tick),
         .mode       (mode_ff[g]),
         .level_next (level_next[g])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_level_ff <= level_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_led0_on = rsp_level_ff[0];
   assign rsp_led1_on = rsp_level_ff[1];
   assign rsp_led2_on = rsp_level_ff[2];

endmodule

/* design/lbmc_checker.sv */
// port-level checker for the blink controller and its bind
`include "assert_macros.svh"

module lbmc_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_led0_on,
   input logic rsp_led1_on,
   input logic rsp_led2_on
);

   logic [lbmc_pkg::LED_COUNT-1:0] leds;
   assign leds = {rsp_led2_on, rsp_led1_on, rsp_led0_on};

   // reset empties the output register
   `LBMC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "rsp_valid after reset")

   // stalled result beat holds its levels
   `LBMC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(leds), "rsp beat changed under stall")

   // empty output side never blocks the input
   `LBMC_ASSERT_NOW(a_empty_ready, clock, reset, !rsp_valid, req_ready, "req blocked with no result pending")

   // draining output side never blocks the input
   `LBMC_ASSERT_NOW(a_drain_ready, clock, reset, rsp_ready, req_ready, "req blocked while rsp drains")

endmodule

bind led_blink_mode_controller_core lbmc_checker u_lbmc_checker (.*);

/* sim/led_blink_mode_controller_core_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the three-led blink mode controller
module led_blink_mode_controller_core_tb;

   // beats accepted on no channel for this many cycles means a hang
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_COUNT = 14;
   localparam int TICKS_PER_PHASE = 125;
   // result passes through the input and output registers, leave slack
   localparam int DRAIN_CYCLES = 8;
   localparam int GAP_CAP = 60;
   localparam int STIM_ROWS = 31;
   localparam int CSR_W = lbmc_pkg::CSR_INDEX_WIDTH;
   localparam int LEDS = lbmc_pkg::LED_COUNT;
   // only index left over in the two-bit csr address space
   localparam logic [CSR_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;

   // one line of the directed table
   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_W-1:0]      index;
      lbmc_pkg::mode_type    mode;
      logic                  advance;
      logic [4:0]            count;
      logic                  has_level;
      logic [LEDS-1:0]       level;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_advance = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_led0_on;
   logic rsp_led1_on;
   logic rsp_led2_on;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_W-1:0] csr_index = lbmc_pkg::CSR_MODE_LED0;
   logic [lbmc_pkg::MODE_WIDTH-1:0] csr_data = lbmc_pkg::MODE_OFF;

   // own copy of the block state for prediction
   lbmc_pkg::mode_type   led_mode [LEDS];
   lbmc_pkg::mode_type   prev_mode [LEDS];
   logic [LEDS-1:0]      saved_level;
   logic [LEDS-1:0]      led_level;
   logic                 div_two;
   logic [2:0]           div_five;
   logic [3:0]           div_ten;

   // led levels expected on the rsp channel, oldest first
   logic [LEDS-1:0] level_expect_q [$];

   stim_row_type stim_table [STIM_ROWS];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int error_count = 0;
   int tick_count = 0;
   int hold_count = 0;
   int csr_count = 0;
   int result_count = 0;
   int stall_cycles = 0;

   led_blink_mode_controller_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_advance (req_advance),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_led0_on (rsp_led0_on),
      .rsp_led1_on (rsp_led1_on),
      .rsp_led2_on (rsp_led2_on),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // back to the reset state: everything off, dividers at zero
   task automatic clear_levels();
      int k;
      for (k = 0; k < LEDS; k++) begin
         led_mode[k] = lbmc_pkg::MODE_OFF;
         prev_mode[k] = lbmc_pkg::MODE_OFF;
      end
      saved_level = '0;
      led_level = '0;
      div_two = 1'b0;
      div_five = '0;
      div_ten = '0;
   endtask

   // levels after one tick (or hold) beat
   function automatic logic [LEDS-1:0] predict_levels(input logic adv);
      int k;
      logic flip;
      if (adv) begin
         // each divider counts up and wraps to zero past its top
         div_two = (div_two == lbmc_pkg::DIV_TWO_TOP) ? 1'b0 : div_two + 1'b1;
         div_five = (div_five == lbmc_pkg::DIV_FIVE_TOP) ? 3'd0 : div_five + 3'd1;
         div_ten = (div_ten == lbmc_pkg::DIV_TEN_TOP) ? 4'd0 : div_ten + 4'd1;
         for (k = 0; k < LEDS; k++) begin
            // mode change: save on a change to any mode but off, restore on a change back to off
            if (led_mode[k] != prev_mode[k]) begin
               prev_mode[k] = led_mode[k];
               if (led_mode[k] != lbmc_pkg::MODE_OFF)
                  saved_level[k] = led_level[k];
               else
                  led_level[k] = saved_level[k];
            end
            flip = 1'b0;
            case (led_mode[k])
               lbmc_pkg::MODE_EVERY1:    flip = 1'b1;
               lbmc_pkg::MODE_EVERY2:    flip = (div_two == 1'b0);
               lbmc_pkg::MODE_EVERY5:    flip = (div_five == 3'd0);
               lbmc_pkg::MODE_EVERY10:   flip = (div_ten == 4'd0);
               lbmc_pkg::MODE_FORCE_OFF: led_level[k] = 1'b0;
               lbmc_pkg::MODE_FORCE_ON:  led_level[k] = 1'b1;
               default: ;
            endcase
            if (flip)
               led_level[k] = ~led_level[k];
         end
      end
      return led_level;
   endfunction

   function automatic stim_row_type tick_row(input logic adv, input logic [4:0] count,
                                             input logic has_level,
                                             input logic [LEDS-1:0] level);
      return '{ROW_TICK, lbmc_pkg::CSR_MODE_LED0, lbmc_pkg::MODE_OFF, adv, count,
               has_level, level};
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_W-1:0] idx,
                                            input lbmc_pkg::mode_type m);
      return '{ROW_CSR, idx, m, 1'b0, 5'd0, 1'b0, 3'b000};
   endfunction

   // one req beat, after a random gap; valid is left high for the caller
   task automatic send_tick(input logic adv, input logic has_level,
                            input logic [LEDS-1:0] level);
      int gap;
      logic [LEDS-1:0] predicted;
      gap = 0;
      while (gap < GAP_CAP && $urandom_range(99) < sender_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_advance <= adv;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      // predictor always runs so its state tracks the block
      predicted = predict_levels(adv);
      level_expect_q.push_back(has_level ? level : predicted);
      if (adv)
         tick_count++;
      else
         hold_count++;
   endtask

   // one csr beat; valid is left high so writes can go back to back
   task automatic write_mode(input logic [CSR_W-1:0] idx, input lbmc_pkg::mode_type m);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= m;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      if (idx < LEDS)
         led_mode[idx] = m;
      csr_count++;
   endtask

   // stop sending and let every expected result come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (level_expect_q.size() != 0)
         @(posedge clock);
   endtask

   // receiver backpressure, redrawn every cycle
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);

   // compare every rsp beat with the oldest expectation
   always @(posedge clock) begin : rsp_check
      logic [LEDS-1:0] seen;
      logic [LEDS-1:0] want;
      int k;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_led2_on, rsp_led1_on, rsp_led0_on};
         result_count++;
         if (level_expect_q.size() == 0) begin
            $display("%0t: rsp beat with nothing expected, expected none, got %b",
                     $time, seen);
            error_count++;
         end else begin
            want = level_expect_q.pop_front();
            for (k = 0; k < LEDS; k++)
               if (seen[k] !== want[k]) begin
                  $display("%0t: led%0d level mismatch, expected %b, got %b",
                           $time, k, want[k], seen[k]);
                  error_count++;
               end
         end
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, %0d cycles without a beat, %0d results outstanding",
                  $time, stall_cycles, level_expect_q.size());
         $display("led_blink_mode_controller_core test failed");
         $finish;
      end
   end

   initial begin : stimulus
      int r;
      int p;
      int i;
      int k;
      clear_levels();

      // directed table, levels typed in only where they are obvious
      stim_table = '{
         tick_row(1'b0, 5'd1, 1'b1, 3'b000),       // hold right after reset
         tick_row(1'b1, 5'd1, 1'b1, 3'b000),       // off holds the reset level
         csr_row(lbmc_pkg::CSR_MODE_LED0, lbmc_pkg::MODE_FORCE_ON),
         csr_row(lbmc_pkg::CSR_MODE_LED1, lbmc_pkg::MODE_FORCE_OFF),
         csr_row(lbmc_pkg::CSR_MODE_LED2, lbmc_pkg::MODE_EVERY1),
         tick_row(1'b1, 5'd1, 1'b1, 3'b101),       // fastest mode, one toggle
         tick_row(1'b0, 5'd1, 1'b1, 3'b101),       // hold keeps the levels
         tick_row(1'b1, 5'd1, 1'b1, 3'b001),       // toggles back, once only
         csr_row(CSR_UNUSED, lbmc_pkg::MODE_FORCE_ON),     // out of range, ignored
         tick_row(1'b1, 5'd1, 1'b0, 3'b000),
         csr_row(lbmc_pkg::CSR_MODE_LED0, lbmc_pkg::MODE_OFF),  // back to off, restore
         csr_row(lbmc_pkg::CSR_MODE_LED1, lbmc_pkg::MODE_EVERY2),
         csr_row(lbmc_pkg::CSR_MODE_LED2, lbmc_pkg::MODE_EVERY5),
         tick_row(1'b1, 5'd6, 1'b0, 3'b000),
         csr_row(lbmc_pkg::CSR_MODE_LED0, lbmc_pkg::MODE_EVERY10),
         csr_row(lbmc_pkg::CSR_MODE_LED1, lbmc_pkg::MODE_FADE),  // fade does nothing
         csr_row(lbmc_pkg::CSR_MODE_LED2, lbmc_pkg::MODE_OFF),
         tick_row(1'b1, 5'd9, 1'b0, 3'b000),       // runs the ten divider up to its top
         tick_row(1'b0, 5'd1, 1'b0, 3'b000),
         csr_row(lbmc_pkg::CSR_MODE_LED0, lbmc_pkg::MODE_FORCE_OFF),
         csr_row(lbmc_pkg::CSR_MODE_LED1, lbmc_pkg::MODE_FORCE_OFF),
         csr_row(lbmc_pkg::CSR_MODE_LED2, lbmc_pkg::MODE_FORCE_OFF),
         tick_row(1'b1, 5'd1, 1'b1, 3'b000),       // all forced off
         csr_row(lbmc_pkg::CSR_MODE_LED0, lbmc_pkg::MODE_FORCE_ON),
         csr_row(lbmc_pkg::CSR_MODE_LED1, lbmc_pkg::MODE_FORCE_ON),
         csr_row(lbmc_pkg::CSR_MODE_LED2, lbmc_pkg::MODE_FORCE_ON),
         tick_row(1'b1, 5'd1, 1'b1, 3'b111),       // all forced on
         csr_row(lbmc_pkg::CSR_MODE_LED0, lbmc_pkg::MODE_OFF),
         csr_row(lbmc_pkg::CSR_MODE_LED1, lbmc_pkg::MODE_OFF),
         csr_row(lbmc_pkg::CSR_MODE_LED2, lbmc_pkg::MODE_OFF),
         tick_row(1'b1, 5'd1, 1'b0, 3'b000)        // saved levels come back
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, no idling
      for (r = 0; r < STIM_ROWS; r++) begin
         if (stim_table[r].kind == ROW_CSR) begin
            wait_idle();
            write_mode(stim_table[r].index, stim_table[r].mode);
         end else begin
            csr_valid <= 1'b0;
            repeat (stim_table[r].count)
               send_tick(stim_table[r].advance, stim_table[r].has_level,
                         stim_table[r].level);
         end
      end

      // random phases: new modes while idle, then a run of beats
      for (p = 0; p < PHASE_COUNT; p++) begin
         case (p % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 86;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 86;
            end
            default: begin
               sender_idle_pct = 12;
               receiver_stall_pct = 12;
            end
         endcase
         wait_idle();
         for (k = 0; k < LEDS; k++) begin
            // first phases set the fastest mode, fade and off on every led
            if (p == 0)
               write_mode(CSR_W'(k), lbmc_pkg::MODE_EVERY1);
            else if (p == 1)
               write_mode(CSR_W'(k), lbmc_pkg::MODE_FADE);
            else if (p == 2)
               write_mode(CSR_W'(k), lbmc_pkg::MODE_OFF);
            else if ($urandom_range(3) != 0)
               // some leds keep their mode across phases
               write_mode(CSR_W'(k), lbmc_pkg::mode_type'($urandom_range(7)));
         end
         if ($urandom_range(2) == 0)
            write_mode(CSR_UNUSED, lbmc_pkg::mode_type'($urandom_range(7)));
         csr_valid <= 1'b0;
         for (i = 0; i < TICKS_PER_PHASE; i++)
            send_tick($urandom_range(3) != 0, 1'b0, 3'b000);
      end

      // drain with no backpressure
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d tick beats, %0d hold beats, %0d csr writes over %0d phases",
               tick_count, hold_count, csr_count, PHASE_COUNT);
      $display("checked %0d result beats, %0d mismatches", result_count, error_count);
      if (error_count == 0)
         $display("led_blink_mode_controller_core test passed");
      else
         $display("led_blink_mode_controller_core test failed");
      $finish;
   end

endmodule
